/* design/aps_pkg.sv */
package aps_pkg;

	localparam int APS_NUM_SLOTS = 16;
	localparam int APS_TIME_BITS = 16;
	localparam int FIELD_W       = 16;
	localparam int PRIO_W        = 32;
	localparam int CFG_W         = 5;
	localparam int SLOT_FIELD_W  = 4;
	localparam logic [PRIO_W-1:0] RUN_STEP = PRIO_W'(1);
	localparam logic [PRIO_W-1:0] AGE_STEP = PRIO_W'(2);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] remaining;
		logic [FIELD_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} slot_entry_t;

	typedef struct packed {
		logic               arrived;
		logic               busy;
		logic               better;
		logic [PRIO_W-1:0]  prio_eff;
		logic [PRIO_W-1:0]  prio_next;
		logic [FIELD_W-1:0] rem_next;
	} slot_eval_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH
	} aps_state_t;

endpackage

/* design/aps_slot_eval.sv */
module aps_slot_eval import aps_pkg::*; #(
	parameter int TIME_BITS = APS_TIME_BITS
) (
	input  slot_entry_t          entry,
	input  logic                 prio_valid,
	input  logic [TIME_BITS-1:0] cur_time,
	input  logic                 found,
	input  logic [PRIO_W-1:0]    best_prio,
	input  logic                 is_winner,
	output slot_eval_t           eval
);

	localparam int TW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

	logic              arrived;
	logic              busy;
	logic [PRIO_W-1:0] prio_eff;
	logic [PRIO_W:0]   prio_sum;

	always_comb begin
		arrived  = TW'(entry.arrival) <= TW'(cur_time);
		busy     = entry.remaining != '0;
		// a slot never loaded reads as priority zero
		prio_eff = prio_valid ? entry.prio : '0;
		prio_sum = {1'b0, prio_eff} + {1'b0, (is_winner ? RUN_STEP : AGE_STEP)};

		eval.arrived   = arrived;
		eval.busy      = busy;
		eval.better    = arrived && busy && (!found || prio_eff > best_prio);
		eval.prio_eff  = prio_eff;
		eval.prio_next = prio_sum[PRIO_W] ? '1 : prio_sum[PRIO_W-1:0];
		eval.rem_next  = is_winner ? entry.remaining - FIELD_W'(1) : entry.remaining;
	end

endmodule

/* design/aging_priority_scheduler.sv */
// Aging priority scheduler. A load beat (command 0) stores arrival time and burst length
// into a slot and clears its priority; it gives no result. A tick beat (command 1) gives
// one result: among the first num_processes slots that have arrived and still have work,
// the highest priority runs one unit (ties to the lowest slot), the runner gains 1, every
// other arrived slot gains 2, and time advances. Slot entries live in one single-port-read
// memory with a registered read, so a tick takes two passes over the active slots (pick,
// then age and write back). A result may wait at the output while further loads are taken;
// the next tick's result holds until the previous one is taken.
module aging_priority_scheduler import aps_pkg::*; #(
	parameter int NUM_SLOTS = APS_NUM_SLOTS,
	parameter int TIME_BITS = APS_TIME_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_wr_en,
	input  logic [CFG_W-1:0]        cfg_wr_data,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [SLOT_FIELD_W-1:0] slot,
	input  logic [FIELD_W-1:0]      arrival_time,
	input  logic [FIELD_W-1:0]      burst_length,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    ran_valid,
	output logic [SLOT_FIELD_W-1:0] ran_slot,
	output logic                    finished,
	output logic [FIELD_W-1:0]      completion_time,
	output logic [FIELD_W-1:0]      turnaround,
	output logic [FIELD_W-1:0]      waiting,
	output logic                    all_done
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;
	localparam int XW = ((SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W) + 1;
	localparam int TW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

	aps_state_t state_q, state_d;

	logic [CFG_W-1:0]     num_procs_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] time_next;
	logic [CW-1:0]        n_active;

	slot_entry_t          slot_mem [NUM_SLOTS];
	slot_entry_t          rd_data_s1;
	logic                 rd_vld_s1;
	logic [SW-1:0]        rd_idx_s1;
	logic [NUM_SLOTS-1:0] pvalid_q;

	logic [CW-1:0]        cnt_q;
	logic                 found_q;
	logic [SW-1:0]        win_q;
	logic [PRIO_W-1:0]    best_prio_q;
	slot_entry_t          win_ent_q;
	logic [CW-1:0]        busy_cnt_q;

	logic                 out_valid_q;
	logic                 ran_valid_q;
	logic [SLOT_FIELD_W-1:0] ran_slot_q;
	logic                 finished_q;
	logic [FIELD_W-1:0]   completion_q;
	logic [FIELD_W-1:0]   turnaround_q;
	logic [FIELD_W-1:0]   waiting_q;
	logic                 all_done_q;

	logic                 issue;
	logic                 pass_end;
	logic                 fin_load;
	logic                 in_acc;
	logic                 slot_in_range;
	logic                 load_wr;
	logic                 upd_wr;
	logic                 wr_en;
	logic [SW-1:0]        wr_addr;
	slot_entry_t          wr_data;
	logic                 is_winner;
	slot_eval_t           ev;

	logic                 fin;
	logic [TW-1:0]        ct_w;
	logic [TW-1:0]        tat_w;
	logic [TW-1:0]        wt_w;
	logic                 done;

	aps_slot_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.entry      (rd_data_s1),
		.prio_valid (pvalid_q[rd_idx_s1]),
		.cur_time   (time_q),
		.found      (found_q),
		.best_prio  (best_prio_q),
		.is_winner  (is_winner),
		.eval       (ev)
	);

	always_comb begin
		n_active = (NW'(num_procs_q) > NW'(NUM_SLOTS)) ? CW'(NUM_SLOTS) : CW'(num_procs_q);
		time_next = (time_q == '1) ? time_q : time_q + TIME_BITS'(1);
		is_winner = found_q && (rd_idx_s1 == win_q);
		slot_in_range = XW'(slot) < XW'(NUM_SLOTS);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		pass_end = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && command == CMD_TICK) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				issue = cnt_q < n_active;
				if (!issue && !rd_vld_s1) begin
					pass_end = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				issue = cnt_q < n_active;
				if (!issue && !rd_vld_s1) begin
					pass_end = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// write port: loads in idle, priority write-back in the update pass
	always_comb begin
		in_acc  = in_valid && in_ready;
		load_wr = in_acc && command == CMD_LOAD && slot_in_range;
		upd_wr  = state_q == ST_UPDATE && rd_vld_s1 && ev.arrived;
		wr_en   = load_wr || upd_wr;
		if (load_wr) begin
			wr_addr           = SW'(slot);
			wr_data.arrival   = arrival_time;
			wr_data.remaining = (burst_length == '0) ? FIELD_W'(1) : burst_length;
			wr_data.burst     = (burst_length == '0) ? FIELD_W'(1) : burst_length;
			wr_data.prio      = '0;
		end else begin
			wr_addr           = rd_idx_s1;
			wr_data.arrival   = rd_data_s1.arrival;
			wr_data.remaining = ev.rem_next;
			wr_data.burst     = rd_data_s1.burst;
			wr_data.prio      = ev.prio_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_mem[wr_addr] <= wr_data;
		if (issue) begin
			rd_data_s1 <= slot_mem[cnt_q[SW-1:0]];
			rd_idx_s1  <= cnt_q[SW-1:0];
		end
	end

	// result of the tick
	always_comb begin
		fin   = found_q && win_ent_q.remaining == FIELD_W'(1);
		ct_w  = TW'(time_next);
		tat_w = ct_w - TW'(win_ent_q.arrival);
		wt_w  = (tat_w >= TW'(win_ent_q.burst)) ? tat_w - TW'(win_ent_q.burst) : '0;
		done  = busy_cnt_q == CW'(fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_procs_q <= CFG_W'(1);
			time_q      <= '0;
			rd_vld_s1   <= 1'b0;
			pvalid_q    <= '0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			busy_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_wr_en) num_procs_q <= cfg_wr_data;
			if (load_wr) pvalid_q[SW'(slot)] <= 1'b1;
			if (upd_wr) pvalid_q[rd_idx_s1] <= 1'b1;

			if (state_q == ST_IDLE || pass_end) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + CW'(1);

			if (in_acc && command == CMD_TICK) begin
				found_q    <= 1'b0;
				busy_cnt_q <= '0;
			end else if (state_q == ST_SCAN && rd_vld_s1) begin
				if (ev.better) found_q <= 1'b1;
				if (ev.busy) busy_cnt_q <= busy_cnt_q + CW'(1);
			end

			if (fin_load) begin
				time_q      <= time_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_vld_s1 && ev.better) begin
			win_q       <= rd_idx_s1;
			best_prio_q <= ev.prio_eff;
			win_ent_q   <= rd_data_s1;
		end
		if (fin_load) begin
			ran_valid_q  <= found_q;
			ran_slot_q   <= found_q ? SLOT_FIELD_W'(win_q) : '0;
			finished_q   <= fin;
			completion_q <= fin ? ct_w[FIELD_W-1:0] : '0;
			turnaround_q <= fin ? tat_w[FIELD_W-1:0] : '0;
			waiting_q    <= fin ? wt_w[FIELD_W-1:0] : '0;
			all_done_q   <= done;
		end
	end

	assign out_valid       = out_valid_q;
	assign ran_valid       = ran_valid_q;
	assign ran_slot        = ran_slot_q;
	assign finished        = finished_q;
	assign completion_time = completion_q;
	assign turnaround      = turnaround_q;
	assign waiting         = waiting_q;
	assign all_done        = all_done_q;

endmodule
